// ----- sv/tws_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tws_pkg
// shared constants, codes and the symbol-to-slot mapping of the trie unit
// ----------------------------------------------------------------------------
package tws_pkg;

  // child slots per node: 26 folded letters, space, hyphen, apostrophe
  localparam int SLOTS = 29;

  localparam int SLOT_W = 5;

  // character codes
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7a;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5a;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_HYPHEN  = 8'h2d;
  localparam logic [7:0] CH_APOS    = 8'd39;

  // slots of the punctuation characters
  localparam logic [SLOT_W-1:0] SLOT_SPACE  = SLOT_W'(SLOTS - 3);
  localparam logic [SLOT_W-1:0] SLOT_HYPHEN = SLOT_W'(SLOTS - 2);
  localparam logic [SLOT_W-1:0] SLOT_APOS   = SLOT_W'(SLOTS - 1);

  // result status codes
  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_SYMBOL = 2'd1;
  localparam logic [1:0] STATUS_FULL   = 2'd2;

  // why the current word has stopped walking
  typedef enum logic [1:0] {
    FAIL_NONE   = 2'd0,
    FAIL_SYMBOL = 2'd1,
    FAIL_FULL   = 2'd2,
    FAIL_MISS   = 2'd3
  } fail_e;

  typedef struct packed {
    logic              ok;
    logic [SLOT_W-1:0] idx;
  } slot_t;

  // map a raw byte onto a child slot, case folded
  function automatic slot_t slot_of(logic [7:0] c);
    slot_t s;
    s.ok  = 1'b1;
    s.idx = '0;
    priority if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
      s.idx = SLOT_W'(c - CH_LOWER_A);
    end else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      s.idx = SLOT_W'(c - CH_UPPER_A);
    end else if (c == CH_SPACE) begin
      s.idx = SLOT_SPACE;
    end else if (c == CH_HYPHEN) begin
      s.idx = SLOT_HYPHEN;
    end else if (c == CH_APOS) begin
      s.idx = SLOT_APOS;
    end else begin
      s.ok = 1'b0;
    end
    return s;
  endfunction

endpackage
`default_nettype wire

// ----- sv/tws_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tws_ram
// simple dual-port synchronous ram, one write and one registered read port
// ----------------------------------------------------------------------------
module tws_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, registered, captured while re_i is high
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ----- sv/tws_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tws_ctrl
// per-character sequencer: clearing pass, child lookup, allocation, terminal
// read-modify-write and result generation
// ----------------------------------------------------------------------------
module tws_ctrl #(
  parameter int NODES  = 1024,
  parameter int NODE_W = $clog2(NODES),
  parameter int ADDR_W = $clog2(NODES * tws_pkg::SLOTS)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  output logic                   busy_o,
  input  wire logic              func_i,
  input  wire logic [7:0]        symbol_i,
  input  wire logic              last_i,
  // child store
  output logic                   child_re_o,
  output logic      [ADDR_W-1:0] child_raddr_o,
  input  wire logic [NODE_W-1:0] child_rdata_i,
  output logic                   child_we_o,
  output logic      [ADDR_W-1:0] child_waddr_o,
  output logic      [NODE_W-1:0] child_wdata_o,
  // terminal store
  output logic                   term_re_o,
  output logic      [NODE_W-1:0] term_raddr_o,
  input  wire logic              term_rdata_i,
  output logic                   term_we_o,
  output logic      [NODE_W-1:0] term_waddr_o,
  output logic                   term_wdata_o,
  // results
  output logic                   valid_o,
  output logic                   answer_o,
  output logic      [1:0]        status_o
);

  import tws_pkg::*;

  localparam int UW    = NODE_W + 1;
  localparam int DEPTH = NODES * SLOTS;

  localparam logic [ADDR_W-1:0] SLOTS_A = ADDR_W'(SLOTS);
  localparam logic [ADDR_W-1:0] NODES_A = ADDR_W'(NODES);
  localparam logic [ADDR_W-1:0] LAST_A  = ADDR_W'(DEPTH - 1);
  localparam logic [UW-1:0]     NODES_U = UW'(NODES);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_TERM
  } state_e;

  state_e              state_q, state_d;
  logic [ADDR_W-1:0]   clr_q, clr_d;
  logic [NODE_W-1:0]   cur_q, cur_d;
  logic [UW-1:0]       used_q, used_d;
  fail_e               fail_q, fail_d;
  logic                chg_q, chg_d;
  logic                func_q, func_d;
  logic                last_q, last_d;
  logic [ADDR_W-1:0]   addr_q, addr_d;
  logic                valid_q, valid_d;
  logic                answer_q, answer_d;
  logic [1:0]          status_q, status_d;

  slot_t               slot;
  logic [ADDR_W-1:0]   rd_addr;
  logic                accept;
  fail_e               fail_w;

  assign busy_o = (state_q != ST_IDLE);
  assign accept = start_i && (state_q == ST_IDLE);

  // child entry address of the incoming character
  assign slot    = slot_of(symbol_i);
  assign rd_addr = ADDR_W'(cur_q) * SLOTS_A + ADDR_W'(slot.idx);

  assign child_re_o    = accept;
  assign child_raddr_o = rd_addr;

  // next-state and memory control
  always_comb begin
    state_d       = state_q;
    clr_d         = clr_q;
    cur_d         = cur_q;
    used_d        = used_q;
    fail_d        = fail_q;
    chg_d         = chg_q;
    func_d        = func_q;
    last_d        = last_q;
    addr_d        = addr_q;
    valid_d       = 1'b0;
    answer_d      = 1'b0;
    status_d      = STATUS_OK;
    fail_w        = FAIL_NONE;
    child_we_o    = 1'b0;
    child_waddr_o = addr_q;
    child_wdata_o = used_q[NODE_W-1:0];
    term_we_o     = 1'b0;
    term_waddr_o  = cur_q;
    term_wdata_o  = 1'b0;
    term_re_o     = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        // zero one child entry a cycle, terminal bits on the first rows
        child_we_o    = 1'b1;
        child_waddr_o = clr_q;
        child_wdata_o = '0;
        if (clr_q < NODES_A) begin
          term_we_o    = 1'b1;
          term_waddr_o = clr_q[NODE_W-1:0];
        end
        if (clr_q == LAST_A) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + ADDR_W'(1);
        end
      end

      ST_IDLE: begin
        if (start_i) begin
          func_d = func_i;
          last_d = last_i;
          if (fail_q != FAIL_NONE) begin
            // word already stopped: only the final beat matters
            if (last_i) begin
              valid_d  = 1'b1;
              status_d = (fail_q == FAIL_SYMBOL) ? STATUS_SYMBOL :
                         (fail_q == FAIL_FULL)   ? STATUS_FULL : STATUS_OK;
              cur_d    = '0;
              fail_d   = FAIL_NONE;
              chg_d    = 1'b0;
            end
          end else if (!slot.ok) begin
            if (last_i) begin
              valid_d  = 1'b1;
              status_d = STATUS_SYMBOL;
              cur_d    = '0;
              fail_d   = FAIL_NONE;
              chg_d    = 1'b0;
            end else begin
              fail_d = FAIL_SYMBOL;
            end
          end else begin
            addr_d  = rd_addr;
            state_d = ST_WALK;
          end
        end
      end

      ST_WALK: begin
        // follow the child, or allocate one on insert
        state_d = ST_IDLE;
        if (child_rdata_i != '0) begin
          cur_d = child_rdata_i;
        end else if (func_q) begin
          if (used_q < NODES_U) begin
            child_we_o = 1'b1;
            cur_d      = used_q[NODE_W-1:0];
            used_d     = used_q + UW'(1);
            chg_d      = 1'b1;
          end else begin
            fail_w = FAIL_FULL;
          end
        end else begin
          fail_w = FAIL_MISS;
        end
        if (last_q) begin
          if (fail_w == FAIL_NONE) begin
            term_re_o = 1'b1;
            state_d   = ST_TERM;
          end else begin
            valid_d  = 1'b1;
            status_d = (fail_w == FAIL_FULL) ? STATUS_FULL : STATUS_OK;
            cur_d    = '0;
            fail_d   = FAIL_NONE;
            chg_d    = 1'b0;
          end
        end else begin
          fail_d = fail_w;
        end
      end

      ST_TERM: begin
        // terminal mark of the final node
        if (func_q) begin
          if (!term_rdata_i) begin
            term_we_o    = 1'b1;
            term_wdata_o = 1'b1;
          end
          answer_d = chg_q | !term_rdata_i;
        end else begin
          answer_d = term_rdata_i;
        end
        valid_d  = 1'b1;
        status_d = STATUS_OK;
        cur_d    = '0;
        fail_d   = FAIL_NONE;
        chg_d    = 1'b0;
        state_d  = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign term_raddr_o = cur_d;

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      clr_q    <= '0;
      cur_q    <= '0;
      used_q   <= UW'(1);
      fail_q   <= FAIL_NONE;
      chg_q    <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      cur_q    <= cur_d;
      used_q   <= used_d;
      fail_q   <= fail_d;
      chg_q    <= chg_d;
      valid_q  <= valid_d;
    end
  end

  // beat payload, no reset needed
  always_ff @(posedge clk_i) begin
    func_q   <= func_d;
    last_q   <= last_d;
    addr_q   <= addr_d;
    answer_q <= answer_d;
    status_q <= status_d;
  end

  assign valid_o  = valid_q;
  assign answer_o = answer_q;
  assign status_o = status_q;

endmodule
`default_nettype wire

// ----- sv/trie_word_insert_search_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// trie_word_insert_search_unit
// dictionary trie over a fixed node pool, fed one character per beat
// ----------------------------------------------------------------------------
// After reset the unit runs a clearing pass over the child store, one entry
// per node and slot with busy high, before it takes the first character. A
// character beat is accepted while idle, then the child lookup takes the
// registered read of the child store; the last character of a word that
// reaches a node adds the terminal store read and update. An invalid
// character, and any character of a word that has already failed, is
// handled while idle with no lookup. Each word gives one result on valid_o
// for a single cycle, registered after its last character is taken; the
// receiver cannot hold it off.
module trie_word_insert_search_unit #(
  parameter int NODES = 1024
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  output logic            busy,
  input  wire logic       func_i,
  input  wire logic [7:0] symbol_i,
  input  wire logic       last_i,
  output logic            valid_o,
  output logic            answer_o,
  output logic [1:0]      status_o
);

  import tws_pkg::*;

  localparam int NODE_W = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int DEPTH  = NODES * SLOTS;
  localparam int ADDR_W = $clog2(DEPTH);

  logic              child_re;
  logic [ADDR_W-1:0] child_raddr;
  logic [NODE_W-1:0] child_rdata;
  logic              child_we;
  logic [ADDR_W-1:0] child_waddr;
  logic [NODE_W-1:0] child_wdata;
  logic              term_re;
  logic [NODE_W-1:0] term_raddr;
  logic              term_rdata;
  logic              term_we;
  logic [NODE_W-1:0] term_waddr;
  logic              term_wdata;

  // sequencer
  tws_ctrl #(
    .NODES  (NODES),
    .NODE_W (NODE_W),
    .ADDR_W (ADDR_W)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_o        (busy),
    .func_i        (func_i),
    .symbol_i      (symbol_i),
    .last_i        (last_i),
    .child_re_o    (child_re),
    .child_raddr_o (child_raddr),
    .child_rdata_i (child_rdata),
    .child_we_o    (child_we),
    .child_waddr_o (child_waddr),
    .child_wdata_o (child_wdata),
    .term_re_o     (term_re),
    .term_raddr_o  (term_raddr),
    .term_rdata_i  (term_rdata),
    .term_we_o     (term_we),
    .term_waddr_o  (term_waddr),
    .term_wdata_o  (term_wdata),
    .valid_o       (valid_o),
    .answer_o      (answer_o),
    .status_o      (status_o)
  );

  // child store, one entry per node and slot
  tws_ram #(
    .WIDTH (NODE_W),
    .DEPTH (DEPTH),
    .AW    (ADDR_W)
  ) u_child_ram (
    .clk_i   (clk_i),
    .we_i    (child_we),
    .waddr_i (child_waddr),
    .wdata_i (child_wdata),
    .re_i    (child_re),
    .raddr_i (child_raddr),
    .rdata_o (child_rdata)
  );

  // terminal store, one bit per node
  tws_ram #(
    .WIDTH (1),
    .DEPTH (NODES),
    .AW    (NODE_W)
  ) u_term_ram (
    .clk_i   (clk_i),
    .we_i    (term_we),
    .waddr_i (term_waddr),
    .wdata_i (term_wdata),
    .re_i    (term_re),
    .raddr_i (term_raddr),
    .rdata_o (term_rdata)
  );

endmodule
`default_nettype wire

// ----- sv/tws_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tws_checker
// port-level checks of the trie unit, bound to the top level
// ----------------------------------------------------------------------------
module tws_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       last_i,
  input wire logic       valid_o,
  input wire logic       answer_o,
  input wire logic [1:0] status_o
);

  import tws_pkg::*;

  logic acc_last;
  logic acc_more;

  assign acc_last = start && !busy && last_i;
  assign acc_more = start && !busy && !last_i;

  // a result only follows an accepted final character
  a_result_has_cause : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ($past(acc_last, 1) || $past(acc_last, 2) || $past(acc_last, 3))
  ) else $error("result without a final character");

  // a character that does not end its word gives no result next cycle
  a_no_result_mid_word : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    acc_more |=> !valid_o
  ) else $error("result after a mid-word character");

  // the unit is free again whenever it delivers a result
  a_idle_on_result : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy
  ) else $error("busy while delivering a result");

  // status is one of the three defined codes
  a_status_code : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (status_o == STATUS_OK || status_o == STATUS_SYMBOL ||
                 status_o == STATUS_FULL)
  ) else $error("undefined status code");

  // a failed word never answers true
  a_fail_answers_zero : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (valid_o && status_o != STATUS_OK) |-> !answer_o
  ) else $error("failed word with answer set");

endmodule

bind trie_word_insert_search_unit tws_checker u_tws_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .last_i   (last_i),
  .valid_o  (valid_o),
  .answer_o (answer_o),
  .status_o (status_o)
);
`default_nettype wire
